FILE: hw/rtl/ldr_pkg.sv
// ----------------------------------------------------------------------------
// ldr_pkg
// Shared types, widths and constants of the lens distortion remap address
// generator.
// ----------------------------------------------------------------------------
package ldr_pkg;

  // Geometry
  localparam int unsigned OUT_ROWS = 1200;
  localparam int unsigned OUT_COLS = 1700;
  localparam int unsigned IN_ROWS  = 606;
  localparam int unsigned IN_COLS  = 938;

  // Port widths
  localparam int unsigned ROW_W     = 11;
  localparam int unsigned COL_W     = 11;
  localparam int unsigned SRC_W     = 10;
  localparam int unsigned CFG_W     = 40;
  localparam int unsigned ALPHA_W   = 31;
  localparam int unsigned CFG_IDX_W = 3;

  // Datapath widths
  localparam int unsigned CTR_W     = 12;  // centred coordinate
  localparam int unsigned X_W       = 44;  // x in Q32
  localparam int unsigned Y_W       = 46;  // y in Q32
  localparam int unsigned MUL_IN_W  = 64;
  localparam int unsigned MUL_OUT_W = 62;  // +-2^60 after saturation
  localparam int unsigned MUL_SH_W  = 6;
  localparam int unsigned MUL_LAT   = 4;
  localparam int unsigned T_W       = 51;  // tangential sums, radial terms
  localparam int unsigned ND_W      = 50;  // numerator / denominator
  localparam int unsigned MAG_W     = ND_W - 1;
  localparam int unsigned QI_W      = 28;  // integer bits of the ratio
  localparam int unsigned QF_W      = 32;  // fraction bits of the ratio
  localparam int unsigned DIV_STEPS = QI_W + QF_W;
  localparam int unsigned Q_W       = DIV_STEPS + 1;
  localparam int unsigned DIV_LAT   = DIV_STEPS + 2;
  localparam int unsigned RND_W     = 30;  // rounded source offset
  localparam int unsigned POS_W     = 32;

  // Accept to strobe
  localparam int unsigned TOTAL_LAT = 4 * MUL_LAT + DIV_LAT + 6;

  // Register reset values
  localparam logic signed [CFG_W-1:0]  K1_RST    = 40'sd3418689204;
  localparam logic signed [CFG_W-1:0]  K2_RST    = 40'sd92675984;
  localparam logic signed [CFG_W-1:0]  K3_RST    = 40'sd4650442647;
  localparam logic signed [CFG_W-1:0]  K4_RST    = 40'sd72588828000;
  localparam logic signed [CFG_W-1:0]  P1_RST    = -40'sd682747837;
  localparam logic signed [CFG_W-1:0]  P2_RST    = -40'sd1142244655;
  localparam logic        [ALPHA_W-1:0] ALPHA_RST = 31'd1061856266;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_K1,
    REG_K2,
    REG_K3,
    REG_K4,
    REG_P1,
    REG_P2,
    REG_ALPHA
  } ldr_reg_e;

  typedef struct packed {
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
  } ldr_req_t;

  typedef struct packed {
    logic [SRC_W-1:0] src_row;
    logic [SRC_W-1:0] src_col;
    logic             in_range;
  } ldr_res_t;

  // Carried alongside the radial products
  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic signed [Y_W-1:0] y;
    logic signed [T_W-1:0] k1r2;
    logic signed [T_W-1:0] k3r2;
    logic signed [T_W-1:0] tx;
    logic signed [T_W-1:0] ty;
  } ldr_cside_t;

  // Carried through the divider
  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic signed [Y_W-1:0] y;
    logic signed [T_W-1:0] tx;
    logic signed [T_W-1:0] ty;
  } ldr_dside_t;

  // Carried alongside the final products
  typedef struct packed {
    logic                  den_ok;
    logic signed [T_W-1:0] tx;
    logic signed [T_W-1:0] ty;
  } ldr_eside_t;

endpackage

FILE: hw/rtl/ldr_mulsh.sv
// ----------------------------------------------------------------------------
// ldr_mulsh
// Signed product shifted down by sh_i, rounded half away from zero and
// saturated to +-2^60. Four stages, 32x32 partial products.
// ----------------------------------------------------------------------------
module ldr_mulsh
  import ldr_pkg::*;
(
  input  logic                                  clk_i,
  input  logic signed [ldr_pkg::MUL_IN_W-1:0]   a_i,
  input  logic signed [ldr_pkg::MUL_IN_W-1:0]   b_i,
  input  logic        [ldr_pkg::MUL_SH_W-1:0]   sh_i,
  output logic signed [ldr_pkg::MUL_OUT_W-1:0]  p_o
);

  localparam int unsigned HW = MUL_IN_W / 2;
  localparam int unsigned PW = 2 * MUL_IN_W;

  logic [MUL_IN_W-1:0] am_q, bm_q;
  logic [MUL_LAT-2:0]  neg_q;
  logic [MUL_IN_W-1:0] pp00_q, pp01_q, pp10_q, pp11_q;
  logic [PW-1:0]       sum_d, sum_q, shd;
  logic                ovf;
  logic [MUL_OUT_W-2:0] mag;

  // magnitudes
  always_ff @(posedge clk_i) begin
    am_q     <= a_i[MUL_IN_W-1] ? MUL_IN_W'(-a_i) : MUL_IN_W'(a_i);
    bm_q     <= b_i[MUL_IN_W-1] ? MUL_IN_W'(-b_i) : MUL_IN_W'(b_i);
    neg_q[0] <= a_i[MUL_IN_W-1] ^ b_i[MUL_IN_W-1];
  end

  // partial products
  always_ff @(posedge clk_i) begin
    pp00_q   <= am_q[HW-1:0]        * bm_q[HW-1:0];
    pp01_q   <= am_q[HW-1:0]        * bm_q[MUL_IN_W-1:HW];
    pp10_q   <= am_q[MUL_IN_W-1:HW] * bm_q[HW-1:0];
    pp11_q   <= am_q[MUL_IN_W-1:HW] * bm_q[MUL_IN_W-1:HW];
    neg_q[1] <= neg_q[0];
  end

  // sum plus rounding half
  assign sum_d = {pp11_q, pp00_q}
               + ({{HW{1'b0}}, pp01_q, {HW{1'b0}}})
               + ({{HW{1'b0}}, pp10_q, {HW{1'b0}}})
               + (PW'(1) << (sh_i - MUL_SH_W'(1)));

  always_ff @(posedge clk_i) begin
    sum_q    <= sum_d;
    neg_q[2] <= neg_q[1];
  end

  assign shd = sum_q >> sh_i;
  assign ovf = (shd[PW-1:MUL_OUT_W-1] != '0)
            || (shd[MUL_OUT_W-2] && (shd[MUL_OUT_W-3:0] != '0));
  assign mag = ovf ? {1'b1, {(MUL_OUT_W-2){1'b0}}} : shd[MUL_OUT_W-2:0];

  always_ff @(posedge clk_i) begin
    p_o <= neg_q[2] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

endmodule

FILE: hw/rtl/ldr_div.sv
// ----------------------------------------------------------------------------
// ldr_div
// Pipelined restoring divider: |num| / den in Q32 with num's sign, truncated,
// one quotient bit per stage, saturated when the integer part reaches 2^28.
// ----------------------------------------------------------------------------
module ldr_div
  import ldr_pkg::*;
(
  input  logic                            clk_i,
  input  logic signed [ldr_pkg::ND_W-1:0] num_i,
  input  logic signed [ldr_pkg::ND_W-1:0] den_i,
  input  ldr_pkg::ldr_dside_t             side_i,
  output logic signed [ldr_pkg::Q_W-1:0]  q_o,
  output logic                            den_ok_o,
  output ldr_pkg::ldr_dside_t             side_o
);

  logic [MAG_W-1:0]     r_q    [DIV_STEPS+1];
  logic [MAG_W-1:0]     dd_q   [DIV_STEPS+1];
  logic [QI_W-1:0]      nl_q   [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] q_q    [DIV_STEPS+1];
  logic                 sat_q  [DIV_STEPS+1];
  logic                 nneg_q [DIV_STEPS+1];
  logic                 ok_q   [DIV_STEPS+1];
  ldr_dside_t           sd_q   [DIV_STEPS+1];

  logic [MAG_W-1:0]     nn;
  logic [DIV_STEPS-1:0] qm;

  assign nn = num_i[ND_W-1] ? MAG_W'(-num_i) : MAG_W'(num_i);

  // prep: magnitude, overflow check, first partial remainder
  always_ff @(posedge clk_i) begin
    r_q[0]    <= MAG_W'(nn[MAG_W-1:QI_W]);
    nl_q[0]   <= nn[QI_W-1:0];
    dd_q[0]   <= den_i[MAG_W-1:0];
    q_q[0]    <= '0;
    sat_q[0]  <= {{QI_W{1'b0}}, nn} >= {den_i[MAG_W-1:0], {QI_W{1'b0}}};
    nneg_q[0] <= num_i[ND_W-1];
    ok_q[0]   <= !den_i[ND_W-1] && (den_i != '0);
    sd_q[0]   <= side_i;
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [MAG_W:0] trial;
    logic           ge;

    // dividend bits below the integer boundary are zero once nl drains
    assign trial = {r_q[k], nl_q[k][QI_W-1]};
    assign ge    = trial >= {1'b0, dd_q[k]};

    always_ff @(posedge clk_i) begin
      r_q[k+1]    <= ge ? MAG_W'(trial - {1'b0, dd_q[k]}) : trial[MAG_W-1:0];
      nl_q[k+1]   <= {nl_q[k][QI_W-2:0], 1'b0};
      dd_q[k+1]   <= dd_q[k];
      q_q[k+1]    <= {q_q[k][DIV_STEPS-2:0], ge};
      sat_q[k+1]  <= sat_q[k];
      nneg_q[k+1] <= nneg_q[k];
      ok_q[k+1]   <= ok_q[k];
      sd_q[k+1]   <= sd_q[k];
    end
  end

  assign qm = sat_q[DIV_STEPS] ? '1 : q_q[DIV_STEPS];

  always_ff @(posedge clk_i) begin
    q_o      <= nneg_q[DIV_STEPS] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
    den_ok_o <= ok_q[DIV_STEPS];
    side_o   <= sd_q[DIV_STEPS];
  end

endmodule

FILE: hw/rtl/lens_distortion_remap_address_top.sv
// ----------------------------------------------------------------------------
// lens_distortion_remap_address_top
// Source address generator for lens distortion correction, rational radial
// plus tangential model.
// ----------------------------------------------------------------------------
// Usage:
//   A request (output pixel row and column) is taken on req_i at each clock
//   edge with start_i high; busy_o stays low, so a new request may come every
//   cycle. The result (source row, column and in-range flag) appears on res_o
//   with done_o high for one cycle, in request order. Throughput is one
//   request per cycle.
//   The pipeline is built around the 60-stage divider (one quotient bit per
//   stage) and the four 4-stage multiply groups.
//   Coefficients are written through cfg_we_i / cfg_idx_i / cfg_wdata_i with
//   no wait; writes should happen with no request in flight. Unknown indexes
//   are ignored.
//   Reset clears the in-flight valid chain and loads the default
//   coefficients. The receiver cannot stall: results are never held back.
// ----------------------------------------------------------------------------
module lens_distortion_remap_address_top
  import ldr_pkg::*;
(
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  ldr_pkg::ldr_req_t                 req_i,
  output logic                              done_o,
  output ldr_pkg::ldr_res_t                 res_o,
  input  logic                              cfg_we_i,
  input  logic [ldr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ldr_pkg::CFG_W-1:0]         cfg_wdata_i
);

  localparam logic signed [CTR_W-1:0]     COL_CTR = CTR_W'(OUT_COLS / 2);
  localparam logic signed [CTR_W-1:0]     ROW_CTR = CTR_W'(OUT_ROWS / 2);
  localparam logic signed [POS_W-1:0]     SRC_ROW_CTR = POS_W'(IN_ROWS / 2);
  localparam logic signed [POS_W-1:0]     SRC_COL_CTR = POS_W'(IN_COLS / 2);
  localparam logic signed [POS_W-1:0]     SRC_ROWS = POS_W'(IN_ROWS);
  localparam logic signed [POS_W-1:0]     SRC_COLS = POS_W'(IN_COLS);
  localparam logic signed [MUL_IN_W-1:0]  ONE_Q32 = 64'sh1_0000_0000;
  localparam logic signed [MUL_OUT_W:0]   LIM = 63'sh1000_0000_0000_0000;
  localparam logic [MUL_SH_W-1:0]         SH32 = 6'd32;
  localparam logic [MUL_SH_W-1:0]         SH47 = 6'd47;
  localparam logic [MUL_SH_W-1:0]         SH48 = 6'd48;
  localparam logic [MUL_SH_W-1:0]         SH56 = 6'd56;

  // configuration
  logic signed [CFG_W-1:0]  k1_q, k2_q, k3_q, k4_q, p1_q, p2_q;
  logic        [ALPHA_W-1:0] alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_q    <= K1_RST;
      k2_q    <= K2_RST;
      k3_q    <= K3_RST;
      k4_q    <= K4_RST;
      p1_q    <= P1_RST;
      p2_q    <= P2_RST;
      alpha_q <= ALPHA_RST;
    end else if (cfg_we_i) begin
      case (ldr_reg_e'(cfg_idx_i))
        REG_K1:    k1_q    <= cfg_wdata_i;
        REG_K2:    k2_q    <= cfg_wdata_i;
        REG_K3:    k3_q    <= cfg_wdata_i;
        REG_K4:    k4_q    <= cfg_wdata_i;
        REG_P1:    p1_q    <= cfg_wdata_i;
        REG_P2:    p2_q    <= cfg_wdata_i;
        REG_ALPHA: alpha_q <= cfg_wdata_i[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // valid chain, one bit per pipeline stage
  logic [TOTAL_LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[TOTAL_LAT-2:0], start_i};
    end
  end

  assign busy_o = 1'b0;

  // stage 1: centre, aspect scale
  logic signed [CTR_W-1:0]   c_w, d_w;
  logic signed [Y_W-3:0]     yp_w;
  logic signed [X_W-1:0]     x_q;
  logic signed [Y_W-1:0]     y_q;

  assign c_w  = $signed({1'b0, req_i.out_col}) - COL_CTR;
  assign d_w  = ROW_CTR - $signed({1'b0, req_i.out_row});
  assign yp_w = d_w * $signed({1'b0, alpha_q});

  always_ff @(posedge clk_i) begin
    x_q <= $signed({c_w, 32'b0});
    y_q <= $signed({yp_w, 2'b00});
  end

  // group A: squares and cross product
  logic signed [MUL_OUT_W-1:0] xx_w, yy_w, xy_w;
  logic signed [X_W-1:0]       x_a_q [MUL_LAT];
  logic signed [Y_W-1:0]       y_a_q [MUL_LAT];

  ldr_mulsh u_mul_xx (.clk_i, .a_i(MUL_IN_W'(x_q)), .b_i(MUL_IN_W'(x_q)),
                      .sh_i(SH32), .p_o(xx_w));
  ldr_mulsh u_mul_yy (.clk_i, .a_i(MUL_IN_W'(y_q)), .b_i(MUL_IN_W'(y_q)),
                      .sh_i(SH32), .p_o(yy_w));
  ldr_mulsh u_mul_xy (.clk_i, .a_i(MUL_IN_W'(x_q)), .b_i(MUL_IN_W'(y_q)),
                      .sh_i(SH32), .p_o(xy_w));

  always_ff @(posedge clk_i) begin
    x_a_q[0] <= x_q;
    y_a_q[0] <= y_q;
    for (int i = 1; i < MUL_LAT; i++) begin
      x_a_q[i] <= x_a_q[i-1];
      y_a_q[i] <= y_a_q[i-1];
    end
  end

  // r2 and the tangential sums
  logic signed [MUL_OUT_W-1:0] r2_d, r2_q, sx_q, sy_q, xy_q;
  logic signed [X_W-1:0]       x6_q;
  logic signed [Y_W-1:0]       y6_q;

  assign r2_d = xx_w + yy_w;

  always_ff @(posedge clk_i) begin
    r2_q <= r2_d;
    sx_q <= r2_d + (xx_w <<< 1);
    sy_q <= r2_d + (yy_w <<< 1);
    xy_q <= xy_w;
    x6_q <= x_a_q[MUL_LAT-1];
    y6_q <= y_a_q[MUL_LAT-1];
  end

  // group B
  logic signed [MUL_OUT_W-1:0] r4_w, k1r2_w, k3r2_w, p1xy_w, p2xy_w, p2sx_w, p1sy_w;
  logic signed [X_W-1:0]       x_b_q [MUL_LAT];
  logic signed [Y_W-1:0]       y_b_q [MUL_LAT];

  ldr_mulsh u_mul_r4 (.clk_i, .a_i(MUL_IN_W'(r2_q)), .b_i(MUL_IN_W'(r2_q)),
                      .sh_i(SH56), .p_o(r4_w));
  ldr_mulsh u_mul_k1 (.clk_i, .a_i(MUL_IN_W'(k1_q)), .b_i(MUL_IN_W'(r2_q)),
                      .sh_i(SH48), .p_o(k1r2_w));
  ldr_mulsh u_mul_k3 (.clk_i, .a_i(MUL_IN_W'(k3_q)), .b_i(MUL_IN_W'(r2_q)),
                      .sh_i(SH48), .p_o(k3r2_w));
  ldr_mulsh u_mul_p1xy (.clk_i, .a_i(MUL_IN_W'(p1_q)), .b_i(MUL_IN_W'(xy_q)),
                        .sh_i(SH47), .p_o(p1xy_w));
  ldr_mulsh u_mul_p2xy (.clk_i, .a_i(MUL_IN_W'(p2_q)), .b_i(MUL_IN_W'(xy_q)),
                        .sh_i(SH47), .p_o(p2xy_w));
  ldr_mulsh u_mul_p2sx (.clk_i, .a_i(MUL_IN_W'(p2_q)), .b_i(MUL_IN_W'(sx_q)),
                        .sh_i(SH48), .p_o(p2sx_w));
  ldr_mulsh u_mul_p1sy (.clk_i, .a_i(MUL_IN_W'(p1_q)), .b_i(MUL_IN_W'(sy_q)),
                        .sh_i(SH48), .p_o(p1sy_w));

  always_ff @(posedge clk_i) begin
    x_b_q[0] <= x6_q;
    y_b_q[0] <= y6_q;
    for (int i = 1; i < MUL_LAT; i++) begin
      x_b_q[i] <= x_b_q[i-1];
      y_b_q[i] <= y_b_q[i-1];
    end
  end

  // group C: fourth-power terms
  logic signed [MUL_OUT_W:0]   tx_full, ty_full;
  logic signed [MUL_OUT_W-1:0] k2r4_w, k4r4_w;
  ldr_cside_t                  cside_w;
  ldr_cside_t                  cside_q [MUL_LAT];

  assign tx_full = p1xy_w + p2sx_w;
  assign ty_full = p2xy_w + p1sy_w;

  always_comb begin
    cside_w.x    = x_b_q[MUL_LAT-1];
    cside_w.y    = y_b_q[MUL_LAT-1];
    cside_w.k1r2 = k1r2_w[T_W-1:0];
    cside_w.k3r2 = k3r2_w[T_W-1:0];
    cside_w.tx   = tx_full[T_W-1:0];
    cside_w.ty   = ty_full[T_W-1:0];
  end

  ldr_mulsh u_mul_k2 (.clk_i, .a_i(MUL_IN_W'(k2_q)), .b_i(MUL_IN_W'(r4_w)),
                      .sh_i(SH48), .p_o(k2r4_w));
  ldr_mulsh u_mul_k4 (.clk_i, .a_i(MUL_IN_W'(k4_q)), .b_i(MUL_IN_W'(r4_w)),
                      .sh_i(SH48), .p_o(k4r4_w));

  always_ff @(posedge clk_i) begin
    cside_q[0] <= cside_w;
    for (int i = 1; i < MUL_LAT; i++) begin
      cside_q[i] <= cside_q[i-1];
    end
  end

  // numerator and denominator
  logic signed [MUL_IN_W-1:0] num_full, den_full;
  logic signed [ND_W-1:0]     num_q, den_q;
  ldr_dside_t                 dside_q;

  assign num_full = ONE_Q32 + MUL_IN_W'(cside_q[MUL_LAT-1].k1r2) + MUL_IN_W'(k2r4_w);
  assign den_full = ONE_Q32 + MUL_IN_W'(cside_q[MUL_LAT-1].k3r2) + MUL_IN_W'(k4r4_w);

  always_ff @(posedge clk_i) begin
    num_q      <= num_full[ND_W-1:0];
    den_q      <= den_full[ND_W-1:0];
    dside_q.x  <= cside_q[MUL_LAT-1].x;
    dside_q.y  <= cside_q[MUL_LAT-1].y;
    dside_q.tx <= cside_q[MUL_LAT-1].tx;
    dside_q.ty <= cside_q[MUL_LAT-1].ty;
  end

  // ratio
  logic signed [Q_W-1:0] q_w;
  logic                  den_ok_w;
  ldr_dside_t            dside_w;

  ldr_div u_div (
    .clk_i,
    .num_i    (num_q),
    .den_i    (den_q),
    .side_i   (dside_q),
    .q_o      (q_w),
    .den_ok_o (den_ok_w),
    .side_o   (dside_w)
  );

  // group D: ratio times coordinate
  logic signed [MUL_OUT_W-1:0] xq_w, yq_w;
  ldr_eside_t                  eside_q [MUL_LAT];

  ldr_mulsh u_mul_xq (.clk_i, .a_i(MUL_IN_W'(dside_w.x)), .b_i(MUL_IN_W'(q_w)),
                      .sh_i(SH32), .p_o(xq_w));
  ldr_mulsh u_mul_yq (.clk_i, .a_i(MUL_IN_W'(dside_w.y)), .b_i(MUL_IN_W'(q_w)),
                      .sh_i(SH32), .p_o(yq_w));

  always_ff @(posedge clk_i) begin
    eside_q[0].den_ok <= den_ok_w;
    eside_q[0].tx     <= dside_w.tx;
    eside_q[0].ty     <= dside_w.ty;
    for (int i = 1; i < MUL_LAT; i++) begin
      eside_q[i] <= eside_q[i-1];
    end
  end

  // saturated sums
  logic signed [MUL_OUT_W:0]   xs_w, ys_w;
  logic signed [MUL_OUT_W-1:0] x2_q, y2_q;
  logic                        ok2_q;

  assign xs_w = xq_w + eside_q[MUL_LAT-1].tx;
  assign ys_w = yq_w + eside_q[MUL_LAT-1].ty;

  always_ff @(posedge clk_i) begin
    x2_q  <= (xs_w > LIM) ? MUL_OUT_W'(LIM) :
             (xs_w < -LIM) ? MUL_OUT_W'(-LIM) : xs_w[MUL_OUT_W-1:0];
    y2_q  <= (ys_w > LIM) ? MUL_OUT_W'(LIM) :
             (ys_w < -LIM) ? MUL_OUT_W'(-LIM) : ys_w[MUL_OUT_W-1:0];
    ok2_q <= eside_q[MUL_LAT-1].den_ok;
  end

  // round half away from zero
  logic [MUL_OUT_W-2:0] x2m_w, y2m_w;
  logic [RND_W-2:0]     rxm_w, rym_w;
  logic signed [RND_W-1:0] rx_q, ry_q;
  logic                 ok3_q;

  assign x2m_w = x2_q[MUL_OUT_W-1] ? (MUL_OUT_W-1)'(-x2_q) : x2_q[MUL_OUT_W-2:0];
  assign y2m_w = y2_q[MUL_OUT_W-1] ? (MUL_OUT_W-1)'(-y2_q) : y2_q[MUL_OUT_W-2:0];
  assign rxm_w = (RND_W-1)'((x2m_w + (MUL_OUT_W-1)'(32'h8000_0000)) >> 32);
  assign rym_w = (RND_W-1)'((y2m_w + (MUL_OUT_W-1)'(32'h8000_0000)) >> 32);

  always_ff @(posedge clk_i) begin
    rx_q  <= x2_q[MUL_OUT_W-1] ? -$signed({1'b0, rxm_w}) : $signed({1'b0, rxm_w});
    ry_q  <= y2_q[MUL_OUT_W-1] ? -$signed({1'b0, rym_w}) : $signed({1'b0, rym_w});
    ok3_q <= ok2_q;
  end

  // source position and range check
  logic signed [POS_W-1:0] si_w, sj_w;
  logic                    inr_w;
  ldr_res_t                res_q;

  assign si_w  = SRC_ROW_CTR - POS_W'(ry_q);
  assign sj_w  = SRC_COL_CTR + POS_W'(rx_q);
  assign inr_w = ok3_q && !si_w[POS_W-1] && (si_w < SRC_ROWS)
                       && !sj_w[POS_W-1] && (sj_w < SRC_COLS);

  always_ff @(posedge clk_i) begin
    res_q.src_row  <= inr_w ? si_w[SRC_W-1:0] : '0;
    res_q.src_col  <= inr_w ? sj_w[SRC_W-1:0] : '0;
    res_q.in_range <= inr_w;
  end

  assign res_o  = res_q;
  assign done_o = vld_q[TOTAL_LAT-1];

endmodule
